>>> src/alignment_run_encoder_base64_defines.svh
// ----------------------------------------------------------------------------
// Alignment run encoder - assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ALIGNMENT_RUN_ENCODER_BASE64_DEFINES_SVH
`define ALIGNMENT_RUN_ENCODER_BASE64_DEFINES_SVH

// Implication that must hold at every edge outside reset.
`define ARE64_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ARE64_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

>>> src/are64_pkg.sv
// ----------------------------------------------------------------------------
// are64_pkg
// Types, constants and the base64url character map of the run encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package are64_pkg;

  localparam int RUN_BITS = 16;
  localparam logic [15:0] RUN_MASK = (RUN_BITS >= 16) ? 16'hFFFF :
                                     16'((1 << RUN_BITS) - 1);

  localparam logic [1:0] KIND_M = 2'd0;
  localparam logic [1:0] KIND_I = 2'd1;
  localparam logic [1:0] KIND_D = 2'd2;

  localparam int W_W   = 17;  // run - 1 + 2^order
  localparam int SEG_W = 33;  // header bits plus exp-Golomb code
  localparam int BUF_W = 38;  // leftover bits plus one segment
  localparam int LEN_W = 6;

  typedef struct packed {
    logic             first;
    logic             last;
    logic [SEG_W-1:0] seg;
    logic [LEN_W-1:0] seg_len;
  } are64_ent_t;

  typedef struct packed {
    logic             emitting;
    logic [LEN_W-1:0] cnt;
  } are64_bstat_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26)       c = 7'd65 + {1'b0, v};
    else if (v < 6'd52)  c = 7'd71 + {1'b0, v};
    else if (v < 6'd62)  c = {1'b0, v} - 7'd4;
    else if (v == 6'd62) c = 7'd45;
    else                 c = 7'd95;
    return c;
  endfunction

endpackage

>>> src/are64_front.sv
// ----------------------------------------------------------------------------
// are64_front
// Classify elements: header bits, exp-Golomb word and segment length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module are64_front import are64_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [15:0] run_length_i,
  input  logic       first_i,
  input  logic       last_i,
  output logic       enq_valid_o,
  input  logic       enq_ready_i,
  output are64_ent_t enq_ent_o
);

  logic           s1_valid_q, s1_valid_d;
  logic           s1_match_q;
  logic [W_W-1:0] s1_w_q;
  logic [1:0]     s1_hdr_q, s1_hdr_len_q;
  logic           s1_first_q, s1_last_q;
  logic [1:0]     prev_kind_q;

  logic           in_fire;
  logic [1:0]     kind_fix;
  logic [15:0]    run;
  logic [W_W-1:0] w_d;
  logic [1:0]     hdr_d, hdr_len_d;
  logic           tbit;

  assign in_ready_o = !s1_valid_q || enq_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    kind_fix = (kind_i == 2'd3) ? KIND_D : kind_i;
    run      = run_length_i & RUN_MASK;
    if (run == 16'd0) run = 16'd1;
    w_d = {1'b0, run} - 17'd1 + ((kind_fix == KIND_M) ? 17'd16 : 17'd1);
    if (prev_kind_q == KIND_D) tbit = (kind_fix == KIND_I);
    else                       tbit = (kind_fix == KIND_D);
    if (first_i) begin
      unique case (kind_fix)
        KIND_M:  begin hdr_d = 2'b01; hdr_len_d = 2'd1; end
        KIND_I:  begin hdr_d = 2'b00; hdr_len_d = 2'd2; end
        default: begin hdr_d = 2'b01; hdr_len_d = 2'd2; end
      endcase
    end else begin
      hdr_d     = {1'b0, tbit};
      hdr_len_d = 2'd1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire)          s1_valid_d = 1'b1;
    else if (enq_ready_i) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      prev_kind_q <= KIND_M;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_fire) prev_kind_q <= kind_fix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_match_q   <= (kind_fix == KIND_M);
      s1_w_q       <= w_d;
      s1_hdr_q     <= hdr_d;
      s1_hdr_len_q <= hdr_len_d;
      s1_first_q   <= first_i;
      s1_last_q    <= last_i;
    end
  end

  // Code length: leading zeros plus the word itself.
  logic [4:0]       nb;
  logic [LEN_W-1:0] len;

  always_comb begin
    nb = 5'd0;
    for (int i = 0; i < W_W; i++) begin
      if (s1_w_q[i]) nb = 5'(i + 1);
    end
    len = {nb, 1'b0} - 6'd1 - (s1_match_q ? 6'd4 : 6'd0);
  end

  assign enq_valid_o       = s1_valid_q;
  assign enq_ent_o.first   = s1_first_q;
  assign enq_ent_o.last    = s1_last_q;
  assign enq_ent_o.seg     = (SEG_W'(s1_hdr_q) << len) | SEG_W'(s1_w_q);
  assign enq_ent_o.seg_len = LEN_W'(s1_hdr_len_q) + len;

endmodule

>>> src/are64_fifo.sv
// ----------------------------------------------------------------------------
// are64_fifo
// Two-entry queue of classified elements between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module are64_fifo import are64_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  are64_ent_t push_ent_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output are64_ent_t pop_ent_o
);

  are64_ent_t ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o    = (count_q == 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;
  assign pop_ent_o = ent_q[rd_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop)      count_d = count_q + 2'd1;
    else if (do_pop && !do_push) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_q] <= push_ent_i;
  end

endmodule

>>> src/are64_back.sv
// ----------------------------------------------------------------------------
// are64_back
// Bit packer: append segments MSB first, emit 6-bit groups as characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module are64_back import are64_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  are64_ent_t   q_ent_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [6:0]   char_code_o,
  output logic         end_of_domain_o,
  output are64_bstat_t stat_o
);

  logic [BUF_W-1:0] buf_q, buf_d;   // left-aligned pending bits
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             last_q;
  logic             out_valid_q;
  logic [6:0]       char_q;
  logic             eod_q;

  logic             emitting, emit_fire, load;
  logic [LEN_W-1:0] base_cnt, sh;
  logic [BUF_W-1:0] base_buf;

  assign emitting  = (cnt_q >= 6'd6) || (last_q && cnt_q != 6'd0);
  assign emit_fire = emitting && (!out_valid_q || out_ready_i);
  assign load      = !emitting && q_valid_i;
  assign q_pop_o   = load;

  always_comb begin
    base_cnt = q_ent_i.first ? '0 : cnt_q;
    base_buf = q_ent_i.first ? '0 : buf_q;
    sh       = LEN_W'(BUF_W) - base_cnt - q_ent_i.seg_len;
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    if (load) begin
      buf_d = base_buf | (BUF_W'(q_ent_i.seg) << sh);
      cnt_d = base_cnt + q_ent_i.seg_len;
    end else if (emit_fire) begin
      // shift out one group; a flush drops the zero padding
      buf_d = buf_q << 6;
      cnt_d = (cnt_q >= 6'd6) ? cnt_q - 6'd6 : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
      if (load) last_q <= q_ent_i.last;
      if (emit_fire)        out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      char_q <= b64_char(buf_q[BUF_W-1 -: 6]);
      eod_q  <= last_q && (cnt_q <= 6'd6);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign char_code_o     = char_q;
  assign end_of_domain_o = eod_q;
  assign stat_o.emitting = emitting;
  assign stat_o.cnt      = cnt_q;

endmodule

>>> src/alignment_run_encoder_base64.sv
// An accepted element is registered in the front stage, queued, then loaded and emitted.
// Throughput: one character per cycle while the output is ready and no load is under way;
// an element holds the packer for one load and then for each of its characters (0 to 7).
// The back-end shift register sets the rate: one 6-bit group a cycle unless stalled.
// Reset clears the queue, the pending bits and the previous kind (match).
// ----------------------------------------------------------------------------
// alignment_run_encoder_base64
// Alignment elements to exp-Golomb bit stream to URL-safe base64 characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alignment_run_encoder_base64_defines.svh"

module alignment_run_encoder_base64 import are64_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [1:0] kind, [17:2] run_length, [23:18] zero
  input  logic        s_axis_tuser,  // [0] first_of_domain
  input  logic        s_axis_tlast,  // last_of_domain
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [6:0] char_code, [7] zero
  output logic        m_axis_tlast   // end_of_domain
);

  logic         enq_valid, fifo_full, q_valid, q_pop;
  are64_ent_t   enq_ent, q_ent;
  are64_bstat_t bstat;
  logic [6:0]   char_code;

  are64_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .kind_i       (s_axis_tdata[1:0]),
    .run_length_i (s_axis_tdata[17:2]),
    .first_i      (s_axis_tuser),
    .last_i       (s_axis_tlast),
    .enq_valid_o  (enq_valid),
    .enq_ready_i  (!fifo_full),
    .enq_ent_o    (enq_ent)
  );

  are64_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (enq_valid),
    .push_ent_i (enq_ent),
    .full_o     (fifo_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_ent_o  (q_ent)
  );

  are64_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_ent_i         (q_ent),
    .q_pop_o         (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .char_code_o     (char_code),
    .end_of_domain_o (m_axis_tlast),
    .stat_o          (bstat)
  );

  assign m_axis_tdata = {1'b0, char_code};

  `ARE64_ASSERT_NEVER(a_cnt_range, bstat.cnt > 6'(BUF_W), "pending bit count overran buffer")
  `ARE64_ASSERT_IMP(a_pop_idle, q_pop, !bstat.emitting && q_valid, "segment loaded mid-emission")
  `ARE64_ASSERT_IMP(a_char_set, m_axis_tvalid,
    (m_axis_tdata == 8'd45) || (m_axis_tdata == 8'd95) ||
    (m_axis_tdata >= 8'd48 && m_axis_tdata <= 8'd57) ||
    (m_axis_tdata >= 8'd65 && m_axis_tdata <= 8'd90) ||
    (m_axis_tdata >= 8'd97 && m_axis_tdata <= 8'd122), "character outside base64url set")

endmodule
